// ----- src/dbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbs_pkg: shared types and constants for the decimal subtractor
// Widths, digit limits, sequencer states and the digit unit result type.
// ----------------------------------------------------------------------------
package dbs_pkg;

  // storage sizing
  localparam int MAX_DIGITS = 64;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int DIGIT_W    = 4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W:0]   DEC_BASE  = 5'd10;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_SUB_INIT,
    ST_SUB_RD,
    ST_SUB_WR,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // digit unit result
  typedef struct packed {
    digit_t diff;
    logic   borrow;
  } alu_res_t;

  // digits above nine saturate
  function automatic digit_t clamp_digit(input digit_t d);
    clamp_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
  endfunction

endpackage

// ----- src/decimal_bignum_subtractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bignum_subtractor: signed difference of two decimal numbers
// Digit-serial load, compare, ripple-borrow subtract and emit of the result.
// ----------------------------------------------------------------------------
// Digits enter one per beat, most significant first, first number (operation
// 0) then second (operation 1); leading zeros are dropped and digits past
// MAX_DIGITS are ignored. A digit is taken when start is high and busy low;
// busy stays low while loading. The beat carrying last on the second number
// starts the answer: busy rises and one shared digit subtract unit runs over
// the stored digits, first as a length check and then, only when the lengths
// match, a magnitude compare (read and check states per digit, stopping at
// the first differing digit), then a setup state, then the ripple subtract
// from the least significant digit (read and write states per digit), then
// the emit (read and output states per digit of the stripped difference),
// all bounded by the registered digit RAM reads. done marks each result
// digit for one cycle and the receiver cannot stall it; the last one has
// last_res set, negative holds on every digit, and equal inputs give a
// single zero. busy falls in the cycle that shows the last result digit.
// ----------------------------------------------------------------------------
module decimal_bignum_subtractor
  import dbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  logic   operation,
  input  digit_t digit,
  input  logic   last,
  output logic   done,
  output digit_t digit_res,
  output logic   negative,
  output logic   last_res
);

  state_t   state;
  state_t   state_next;

  cnt_t     first_count;
  cnt_t     second_count;
  cnt_t     idx;
  addr_t    p;
  addr_t    k;
  addr_t    start_idx;
  logic     swap;
  logic     borrow;

  digit_t   din;
  logic     accept;
  logic     first_we;
  logic     second_we;
  addr_t    first_raddr;
  addr_t    second_raddr;
  digit_t   first_rdata;
  digit_t   second_rdata;
  digit_t   diff_rdata;

  cnt_t     nb;
  cnt_t     ns;
  cnt_t     off;
  cnt_t     nb_m1;
  cnt_t     small_pos;
  logic     small_ok;
  addr_t    small_addr;
  logic     cnt_differ;
  logic     cmp_equal_done;
  logic     diff_nz;

  digit_t   alu_a;
  digit_t   alu_b;
  logic     alu_borrow_in;
  alu_res_t alu_res;

  // input beat and digit store enables
  assign accept    = start && !busy;
  assign din       = clamp_digit(digit);
  assign first_we  = accept && (operation == 1'b0) && !(first_count == '0 && din == '0)
                     && (first_count < CNT_W'(MAX_DIGITS));
  assign second_we = accept && (operation == 1'b1) && !(second_count == '0 && din == '0)
                     && (second_count < CNT_W'(MAX_DIGITS));

  // operand lengths and alignment of the smaller number
  assign nb             = swap ? second_count : first_count;
  assign ns             = swap ? first_count : second_count;
  assign off            = nb - ns;
  assign nb_m1          = nb - 1'b1;
  assign small_pos      = {1'b0, p} - off;
  assign small_ok       = ({1'b0, p} >= off);
  assign small_addr     = small_pos[ADDR_W-1:0];
  assign cnt_differ     = (first_count != second_count);
  assign cmp_equal_done = (idx == first_count);
  assign diff_nz        = (alu_res.diff != '0);

  // read address steering
  always_comb begin
    if (state == ST_CMP_RD || state == ST_CMP_CHK) begin
      first_raddr  = idx[ADDR_W-1:0];
      second_raddr = idx[ADDR_W-1:0];
    end else if (swap) begin
      first_raddr  = small_addr;
      second_raddr = p;
    end else begin
      first_raddr  = p;
      second_raddr = small_addr;
    end
  end

  // digit stores
  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_count[ADDR_W-1:0]),
    .wdata (din),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_count[ADDR_W-1:0]),
    .wdata (din),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_diff_ram (
    .clk   (clk),
    .we    (state == ST_SUB_WR),
    .waddr (p),
    .wdata (alu_res.diff),
    .raddr (k),
    .rdata (diff_rdata)
  );

  // shared digit unit
  dbs_digit_alu u_alu (
    .a         (alu_a),
    .b         (alu_b),
    .borrow_in (alu_borrow_in),
    .res       (alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && operation && last) begin
          state_next = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        if (cnt_differ) begin
          state_next = ST_SUB_INIT;
        end else if (cmp_equal_done) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (alu_res.borrow || diff_nz) begin
          state_next = ST_SUB_INIT;
        end else begin
          state_next = ST_CMP_RD;
        end
      end
      ST_SUB_INIT: state_next = ST_SUB_RD;
      ST_SUB_RD:   state_next = ST_SUB_WR;
      ST_SUB_WR: begin
        state_next = (p == '0) ? ST_EMIT_RD : ST_SUB_RD;
      end
      ST_EMIT_RD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        state_next = ({1'b0, k} == nb_m1) ? ST_LOAD : ST_EMIT_RD;
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // state outputs and digit unit operands
  always_comb begin
    busy          = 1'b1;
    alu_a         = first_rdata;
    alu_b         = second_rdata;
    alu_borrow_in = 1'b0;
    unique case (state) inside
      ST_LOAD: begin
        busy = 1'b0;
      end
      ST_SUB_RD, ST_SUB_WR: begin
        alu_a         = swap ? second_rdata : first_rdata;
        alu_b         = small_ok ? (swap ? first_rdata : second_rdata) : '0;
        alu_borrow_in = borrow;
      end
      default: begin
        alu_borrow_in = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // counts and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == ST_EMIT_OUT)
              || (state == ST_CMP_RD && !cnt_differ && cmp_equal_done);
      if (first_we) begin
        first_count <= first_count + 1'b1;
      end
      if (second_we) begin
        second_count <= second_count + 1'b1;
      end
      if (state == ST_CMP_RD && !cnt_differ && cmp_equal_done) begin
        first_count  <= '0;
        second_count <= '0;
      end
      if (state == ST_EMIT_OUT) begin
        if ({1'b0, k} == nb_m1) begin
          first_count  <= '0;
          second_count <= '0;
        end
      end
    end
  end

  // sequencer datapath and result beat
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        idx <= '0;
      end
      ST_CMP_RD: begin
        if (cnt_differ) begin
          swap <= (second_count > first_count);
        end else if (cmp_equal_done) begin
          digit_res <= '0;
          negative  <= 1'b0;
          last_res  <= 1'b1;
        end
      end
      ST_CMP_CHK: begin
        swap <= alu_res.borrow;
        idx  <= idx + 1'b1;
      end
      ST_SUB_INIT: begin
        p         <= nb_m1[ADDR_W-1:0];
        start_idx <= nb_m1[ADDR_W-1:0];
        borrow    <= 1'b0;
      end
      ST_SUB_RD: begin
        borrow <= borrow;
      end
      ST_SUB_WR: begin
        borrow <= alu_res.borrow;
        if (diff_nz) begin
          start_idx <= p;
        end
        if (p == '0) begin
          k <= diff_nz ? '0 : start_idx;
        end else begin
          p <= p - 1'b1;
        end
      end
      ST_EMIT_RD: begin
        k <= k;
      end
      ST_EMIT_OUT: begin
        digit_res <= diff_rdata;
        negative  <= swap;
        last_res  <= ({1'b0, k} == nb_m1);
        k         <= k + 1'b1;
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

`ifndef SYNTH
  // every emit step shows one result digit
  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_OUT) |=> done)
    else $error("emit step did not raise done");

  // result digits of one answer are never on back-to-back cycles
  a_digit_gap: assert property (@(posedge clk) disable iff (rst)
    (done && !last_res) |=> !done)
    else $error("result digits not spaced");

  // the final digit of an answer leaves both numbers empty
  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (done && last_res) |-> (first_count == '0 && second_count == '0))
    else $error("counts not cleared at end of answer");

  // a result is never shown while the block is mid-compare or mid-subtract
  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_LOAD || state == ST_EMIT_RD))
    else $error("done outside an emit or idle cycle");
`endif

endmodule

// ----- src/dbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dbs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/dbs_digit_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbs_digit_alu: one decimal digit subtract with borrow
// Shared by the magnitude compare (borrow in zero) and the ripple subtract.
// ----------------------------------------------------------------------------
module dbs_digit_alu
  import dbs_pkg::*;
(
  input  digit_t   a,
  input  digit_t   b,
  input  logic     borrow_in,
  output alu_res_t res
);

  logic [DIGIT_W:0] sub;
  logic [DIGIT_W:0] wide_a;
  logic [DIGIT_W:0] lo;
  logic [DIGIT_W:0] hi;

  // a - (b + borrow), wrapping by ten when it goes negative
  always_comb begin
    wide_a = {1'b0, a};
    sub    = {1'b0, b} + {{DIGIT_W{1'b0}}, borrow_in};
    lo     = wide_a - sub;
    hi     = wide_a + DEC_BASE - sub;
    if (wide_a >= sub) begin
      res.diff   = lo[DIGIT_W-1:0];
      res.borrow = 1'b0;
    end else begin
      res.diff   = hi[DIGIT_W-1:0];
      res.borrow = 1'b1;
    end
  end

endmodule
